// ===== src/mwg_pkg.sv =====
`timescale 1ns / 1ps

package mwg_pkg;

  localparam int PHASE_BITS     = 32;
  localparam int SINE_ADDR_BITS = 10;
  localparam int SAMPLE_BITS    = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int REG_PHASE_W = 32;
  localparam int AMP_W      = 15;
  localparam int MODE_W     = 2;

  localparam int TBL_N   = 1 << SINE_ADDR_BITS;
  localparam int ROM_AW  = SINE_ADDR_BITS + 1;
  localparam int ROM_W   = 31;
  localparam int Q30_SHIFT = 30;

  typedef enum logic [MODE_W-1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SQUARE = 2'd1,
    WAVE_SAW    = 2'd2,
    WAVE_OFF    = 2'd3
  } wave_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_INC    = 2'd1,
    CFG_OFFSET = 2'd2,
    CFG_AMP    = 2'd3
  } cfg_idx_e;

  typedef logic [ROM_W-1:0] sine_rom_t [TBL_N+1];

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned HALF_Q30    = 64'd1 << 29;
  localparam longint          ONE_Q30     = 64'sd1 << 30;

  // (2n)*(2n+1) for the taylor terms of sin
  localparam longint unsigned TAYLOR_DIV [1:12] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  // sin(k*pi/(2N)) in unsigned Q1.30
  function automatic logic [ROM_W-1:0] sine_q30(int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x    = (HALF_PI_Q30 * longint'(k) + longint'(TBL_N / 2)) / TBL_N;
    x2   = (x * x + HALF_Q30) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 12; n++) begin
      term = (term * x2 + HALF_Q30) >> 30;
      term = (term + (TAYLOR_DIV[n] >> 1)) / TAYLOR_DIV[n];
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > ONE_Q30) begin
      sum = ONE_Q30;
    end
    return sum[ROM_W-1:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t r;
    for (int k = 0; k <= TBL_N; k++) begin
      r[k] = sine_q30(k);
    end
    return r;
  endfunction

  // place a 32-bit fraction of a turn onto the accumulator width
  function automatic logic [PHASE_BITS-1:0] align_phase(logic [REG_PHASE_W-1:0] v);
    logic [PHASE_BITS+REG_PHASE_W-1:0] w;
    w = {v, {PHASE_BITS{1'b0}}};
    return w[PHASE_BITS+REG_PHASE_W-1 -: PHASE_BITS];
  endfunction

endpackage

// ===== src/mwg_if.sv =====
`timescale 1ns / 1ps

interface mwg_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface mwg_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mwg_pkg::SAMPLE_BITS-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// ===== src/multi_waveform_generator.sv =====
`timescale 1ns / 1ps

// Direct digital synthesis generator: every input word asks for one sample and
// yields exactly one output word. A 32-bit phase accumulator is sampled (after an
// optional restart to phase zero) and then advanced by phase_increment. Sine
// mode reads a 1025-entry quarter-wave ROM at accumulator plus phase_offset,
// square and sawtooth modes derive the sample from the accumulator directly,
// and each result is scaled by amplitude and rounded to a signed 16-bit value
// (off mode yields zero). The block takes one word per clock and delivers one
// sample per clock while the output is not stalled; each request is captured
// with its phase, then registered ROM read, amplitude multiply, and round and
// saturate into the output register. Stages advance independently, so requests
// keep flowing into empty stages while the output waits. The user must write
// configuration through cfg_we_i / cfg_idx_i / cfg_data_i only while no sample
// is in flight; the block itself does not enforce this.
module multi_waveform_generator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mwg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mwg_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  mwg_in_if.sink                           in_i,
  mwg_out_if.source                        out_o
);

  localparam int P      = mwg_pkg::PHASE_BITS;
  localparam int S      = mwg_pkg::SAMPLE_BITS;
  localparam int AB     = mwg_pkg::SINE_ADDR_BITS;
  localparam int OP_W   = (mwg_pkg::ROM_W > P) ? mwg_pkg::ROM_W : P;
  localparam int MUL_W  = mwg_pkg::AMP_W + OP_W;
  localparam int MAG_W  = mwg_pkg::AMP_W + 1;
  localparam int SAT_W  = (MAG_W > S) ? MAG_W : S;
  localparam logic [SAT_W-1:0] LIM = SAT_W'((64'd1 << (S - 1)) - 64'd1);
  localparam logic [MUL_W:0] SINE_RND = (MUL_W+1)'(1) << (mwg_pkg::Q30_SHIFT - 1);
  localparam logic [MUL_W:0] SAW_RND  = (MUL_W+1)'(1) << (P - 2);
  localparam logic [P-1:0]   HALF     = P'(1) << (P - 1);

  localparam mwg_pkg::sine_rom_t SineRom = mwg_pkg::build_sine_rom();

  // configuration
  mwg_pkg::wave_e                   mode_q;
  logic [mwg_pkg::REG_PHASE_W-1:0]  inc_q;
  logic [mwg_pkg::REG_PHASE_W-1:0]  offset_q;
  logic [mwg_pkg::AMP_W-1:0]        amp_q;

  // pipeline
  logic [P-1:0]                 acc_q, acc_d;
  logic                         s1_vld_q, s2_vld_q, s3_vld_q, out_vld_q;
  logic [P-1:0]                 s1_phase_q;
  logic [mwg_pkg::ROM_W-1:0]    rom_q;
  logic [P-1:0]                 s2_d_q;
  logic                         s2_neg_q;
  logic [MUL_W-1:0]             s3_prod_q;
  logic                         s3_neg_q;
  logic [S-1:0]                 sample_q;

  logic load1, load2, load3, load_o, in_fire;
  logic [P-1:0]           phase0;
  logic [P-1:0]           sine_p;
  logic [1:0]             quad;
  logic [AB-1:0]          tbl_idx;
  logic [mwg_pkg::ROM_AW-1:0] rom_addr;
  logic                   half_bit;
  logic [P-1:0]           saw_d;
  logic                   neg1;
  logic [OP_W-1:0]        mul_op;
  logic [MUL_W-1:0]       prod_d;
  logic [MUL_W:0]         sine_sum, saw_sum;
  logic [SAT_W-1:0]       mag, sat;
  logic [S-1:0]           sat_s, sample_d;

  // each stage loads when it is empty or its content moves on
  assign load_o  = !out_vld_q || out_o.ready;
  assign load3   = !s3_vld_q || load_o;
  assign load2   = !s2_vld_q || load3;
  assign load1   = !s1_vld_q || load2;
  assign in_fire = in_i.valid && load1;

  assign in_i.ready   = load1;
  assign out_o.valid  = out_vld_q;
  assign out_o.sample = signed'(sample_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= mwg_pkg::WAVE_SINE;
      inc_q    <= '0;
      offset_q <= '0;
      amp_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (mwg_pkg::cfg_idx_e'(cfg_idx_i))
        mwg_pkg::CFG_MODE:   mode_q   <= mwg_pkg::wave_e'(cfg_data_i[mwg_pkg::MODE_W-1:0]);
        mwg_pkg::CFG_INC:    inc_q    <= cfg_data_i[mwg_pkg::REG_PHASE_W-1:0];
        mwg_pkg::CFG_OFFSET: offset_q <= cfg_data_i[mwg_pkg::REG_PHASE_W-1:0];
        mwg_pkg::CFG_AMP:    amp_q    <= cfg_data_i[mwg_pkg::AMP_W-1:0];
      endcase
    end
  end

  // stage 0: phase for this word, accumulator advance
  always_comb begin
    phase0 = in_i.restart ? '0 : acc_q;
    acc_d  = phase0 + mwg_pkg::align_phase(inc_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_fire) begin
        acc_q <= acc_d;
      end
      if (load1) begin
        s1_vld_q <= in_i.valid;
      end
      if (load2) begin
        s2_vld_q <= s1_vld_q;
      end
      if (load3) begin
        s3_vld_q <= s2_vld_q;
      end
      if (load_o) begin
        out_vld_q <= s3_vld_q;
      end
    end
  end

  // stage 1: quarter-wave address, sawtooth distance, sign
  always_comb begin
    sine_p   = s1_phase_q + mwg_pkg::align_phase(offset_q);
    quad     = sine_p[P-1 -: 2];
    tbl_idx  = sine_p[P-3 -: AB];
    rom_addr = quad[0] ? (mwg_pkg::ROM_AW'(mwg_pkg::TBL_N) - {1'b0, tbl_idx})
                       : {1'b0, tbl_idx};
    half_bit = s1_phase_q[P-1];
    saw_d    = half_bit ? {1'b0, s1_phase_q[P-2:0]} : (HALF - s1_phase_q);
    unique case (mode_q)
      mwg_pkg::WAVE_SINE:   neg1 = quad[1];
      mwg_pkg::WAVE_SQUARE: neg1 = half_bit;
      mwg_pkg::WAVE_SAW:    neg1 = !half_bit;
      default:              neg1 = 1'b0;
    endcase
  end

  // stage 2: amplitude multiply
  always_comb begin
    mul_op = (mode_q == mwg_pkg::WAVE_SINE) ? OP_W'(rom_q) : OP_W'(s2_d_q);
    prod_d = MUL_W'(amp_q) * MUL_W'(mul_op);
  end

  // stage 3: round, saturate, apply sign
  always_comb begin
    sine_sum = {1'b0, s3_prod_q} + SINE_RND;
    saw_sum  = {1'b0, s3_prod_q} + SAW_RND;
    unique case (mode_q)
      mwg_pkg::WAVE_SINE:   mag = SAT_W'(sine_sum[mwg_pkg::Q30_SHIFT +: MAG_W]);
      mwg_pkg::WAVE_SQUARE: mag = SAT_W'(amp_q);
      mwg_pkg::WAVE_SAW:    mag = SAT_W'(saw_sum[P-1 +: MAG_W]);
      default:              mag = '0;
    endcase
    sat      = (mag > LIM) ? LIM : mag;
    sat_s    = sat[S-1:0];
    sample_d = s3_neg_q ? (S'(0) - sat_s) : sat_s;
  end

  always_ff @(posedge clk_i) begin
    if (load1) begin
      s1_phase_q <= phase0;
    end
    if (load2) begin
      rom_q    <= SineRom[rom_addr];
      s2_d_q   <= saw_d;
      s2_neg_q <= neg1;
    end
    if (load3) begin
      s3_prod_q <= prod_d;
      s3_neg_q  <= s2_neg_q;
    end
    if (load_o) begin
      sample_q <= sample_d;
    end
  end

endmodule

// ===== src/mwg_checker.sv =====
`timescale 1ns / 1ps

module mwg_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [mwg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [mwg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [mwg_pkg::SAMPLE_BITS-1:0] out_sample_i
);

  localparam int S = mwg_pkg::SAMPLE_BITS;
  localparam int W = (mwg_pkg::AMP_W + 1 > S) ? mwg_pkg::AMP_W + 1 : S;
  localparam logic [W-1:0] LIM = W'((64'd1 << (S - 1)) - 64'd1);

  mwg_pkg::wave_e            mode_q;
  logic [mwg_pkg::AMP_W-1:0] amp_q;
  logic [W-1:0]              amp_w, sq_mag;
  logic [S-1:0]              sq_pos, sq_neg;

  // shadow of the mode and amplitude registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= mwg_pkg::WAVE_SINE;
      amp_q  <= '0;
    end else if (cfg_we_i) begin
      if (mwg_pkg::cfg_idx_e'(cfg_idx_i) == mwg_pkg::CFG_MODE) begin
        mode_q <= mwg_pkg::wave_e'(cfg_data_i[mwg_pkg::MODE_W-1:0]);
      end
      if (mwg_pkg::cfg_idx_e'(cfg_idx_i) == mwg_pkg::CFG_AMP) begin
        amp_q <= cfg_data_i[mwg_pkg::AMP_W-1:0];
      end
    end
  end

  always_comb begin
    amp_w  = W'(amp_q);
    sq_mag = (amp_w > LIM) ? LIM : amp_w;
    sq_pos = sq_mag[S-1:0];
    sq_neg = S'(0) - sq_pos;
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_sample_i))
    else $error("stalled output word changed");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  a_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (amp_q == '0 || mode_q == mwg_pkg::WAVE_OFF) |-> out_sample_i == '0)
    else $error("nonzero sample with zero amplitude or no waveform");

  a_square_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && mode_q == mwg_pkg::WAVE_SQUARE |->
      out_sample_i == sq_pos || out_sample_i == sq_neg)
    else $error("square sample is not plus or minus amplitude");

endmodule

bind multi_waveform_generator mwg_checker u_mwg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_we_i     (cfg_we_i),
  .cfg_idx_i    (cfg_idx_i),
  .cfg_data_i   (cfg_data_i),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_sample_i (out_o.sample)
);
